// ===== rtl/avm_pkg.sv =====
// shared types and constants for the autoranging averaging voltmeter
// no dependencies; imported by avm_shared_unit and the top level
package avm_pkg;

   // defaults of the top level parameters
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_BLOCK_DEF   = 1023;

   // fixed field widths
   localparam int SMP_FIELD_W = 12;
   localparam int TH_W        = 12;
   localparam int CNT_W       = 10;
   localparam int SCALE_W     = 25;
   localparam int VOLT_W      = 29;
   localparam int RANGE_W     = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int VOLT_FRAC   = 8;

   // stream word widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [RANGE_W-1:0] RANGE_MIN = 3'd1;
   localparam logic [RANGE_W-1:0] RANGE_MAX = 3'd5;

   // register reset values
   localparam logic [TH_W-1:0]    TH_LOW_RST   = 12'd32;
   localparam logic [TH_W-1:0]    TH_HIGH_RST  = 12'd1000;
   localparam logic [CNT_W-1:0]   SPB_RST      = 10'd200;
   localparam logic [SCALE_W-1:0] SCALE_1_RST  = 25'd19934905;
   localparam logic [SCALE_W-1:0] SCALE_2_RST  = 25'd11959124;
   localparam logic [SCALE_W-1:0] SCALE_3_RST  = 25'd6488713;
   localparam logic [SCALE_W-1:0] SCALE_4_RST  = 25'd2097152;
   localparam logic [SCALE_W-1:0] SCALE_5_RST  = 25'd425007;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_THRESHOLD_LOW   = 3'd0,
      REG_THRESHOLD_HIGH  = 3'd1,
      REG_SAMPLES_PER_BLK = 3'd2,
      REG_SCALE_ONE       = 3'd3,
      REG_SCALE_TWO       = 3'd4,
      REG_SCALE_THREE     = 3'd5,
      REG_SCALE_FOUR      = 3'd6,
      REG_SCALE_FIVE      = 3'd7
   } avm_reg_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } avm_op_type;

   typedef struct packed {
      logic       start;
      avm_op_type op;
   } avm_unit_ctl_type;

endpackage

// ===== rtl/avm_shared_unit.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
// depends on avm_pkg
module avm_shared_unit import avm_pkg::*; #(
   parameter int SUM_W = SAMPLE_BITS_DEF + CNT_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  avm_unit_ctl_type                       ctl,
   input  logic [SUM_W-1:0]                       opnd_a,  // multiplicand or divisor
   input  logic [SUM_W+SCALE_W-VOLT_FRAC-1:0]     opnd_b,  // multiplier (left aligned) or dividend
   output logic                                   done,
   output logic [SUM_W+SCALE_W-1:0]               acc,
   output logic [SUM_W+SCALE_W-VOLT_FRAC-1:0]     quot
);

   localparam int PROD_W = SUM_W + SCALE_W;
   localparam int DIV_W  = PROD_W - VOLT_FRAC;
   localparam int ITER_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   avm_op_type        op_ff;
   logic [SUM_W-1:0]  a_ff;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [DIV_W-1:0]  shreg_ff, shreg_in;

   logic              is_div;
   logic              msb;
   logic [PROD_W-1:0] shifted;
   logic [PROD_W-1:0] addend;
   logic [PROD_W:0]   add_res;
   logic              ge;

   // one adder serves both: add for multiply, trial subtract for divide
   always_comb begin
      is_div  = (op_ff == OP_DIV);
      msb     = shreg_ff[DIV_W-1];
      shifted = {acc_ff[PROD_W-2:0], is_div & msb};
      if (is_div) begin
         addend = ~PROD_W'(a_ff);
      end else if (msb) begin
         addend = PROD_W'(a_ff);
      end else begin
         addend = '0;
      end
      add_res = {1'b0, shifted} + {1'b0, addend} + (PROD_W + 1)'(is_div);
      ge      = add_res[PROD_W];

      busy_in  = busy_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      acc_in   = acc_ff;
      shreg_in = shreg_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         acc_in   = '0;
         shreg_in = opnd_b;
         iter_in  = (ctl.op == OP_DIV) ? ITER_W'(DIV_W) : ITER_W'(SCALE_W);
      end else if (busy_ff) begin
         acc_in   = (is_div && !ge) ? shifted : add_res[PROD_W-1:0];
         shreg_in = {shreg_ff[DIV_W-2:0], is_div & ge};
         iter_in  = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         op_ff <= ctl.op;
         a_ff  <= opnd_a;
      end
      acc_ff   <= acc_in;
      shreg_ff <= shreg_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quot = shreg_ff;

endmodule

// ===== rtl/autorange_averaging_voltmeter_unit.sv =====
// autoranging averaging voltmeter, top level
// depends on avm_pkg and avm_shared_unit
//
// usage
//   req channel: one converter sample and the polarity pin level per word
//   rsp channel: one measurement word per block of samples_per_block samples
//   csr port: write-only, index 0..7 as threshold_low, threshold_high,
//     samples_per_block, then the Q9.16 scale factors of ranges one to five
// timing
//   a sample that does not close a block leaves the sequencer idle, so
//   req_tready stays high for the next sample
//   the closing sample starts a sequence on the shared unit: a shift-add
//   multiply of sum by scale, then two restoring divisions by the block
//   length (sum for the average, product / 256 for the voltage), the
//   unit working one bit per cycle
// reset: sum and count cleared, range one, registers to their defaults
// stall: the result waits in the output register; samples still flow in,
//   but a block that finishes meanwhile holds in its last step until the
//   output register frees up
module autorange_averaging_voltmeter_unit import avm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_BLOCK   = MAX_BLOCK_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // sample stream in
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [11:0] sample, rest zero
   input  logic [REQ_USER_W-1:0]   req_tuser,   // [0] polarity_in
   // measurement stream out
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [28:0] voltage, [31:29] range_used,
                                                // [34:32] next_range, rest zero
   output logic [RSP_USER_W-1:0]   rsp_tuser,   // [0] polarity_out, [1] range_command
   // register writes
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [SCALE_W-1:0]      csr_wdata
);

   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int PROD_W = SUM_W + SCALE_W;
   localparam int DIV_W  = PROD_W - VOLT_FRAC;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_VOLT_GO,
      ST_VOLT_WAIT,
      ST_EMIT
   } state_type;

   // configuration registers
   logic [TH_W-1:0]    th_low_ff;
   logic [TH_W-1:0]    th_high_ff;
   logic [CNT_W-1:0]   spb_ff;
   logic [SCALE_W-1:0] scale1_ff, scale2_ff, scale3_ff, scale4_ff, scale5_ff;

   // datapath and control
   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic               pol_ff, pol_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   avg_ff, avg_in;
   logic [VOLT_W-1:0]  volt_ff, volt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VOLT_W-1:0]  rsp_volt_ff, rsp_volt_in;
   logic [RANGE_W-1:0] rsp_used_ff, rsp_used_in;
   logic [RANGE_W-1:0] rsp_next_ff, rsp_next_in;
   logic               rsp_pol_ff, rsp_pol_in;
   logic               rsp_cmd_ff, rsp_cmd_in;

   // shared unit hookup
   avm_unit_ctl_type   unit_ctl;
   logic [SUM_W-1:0]   unit_a;
   logic [DIV_W-1:0]   unit_b;
   logic               unit_done;
   logic [PROD_W-1:0]  unit_acc;
   logic [DIV_W-1:0]   unit_quot;

   logic [SAMPLE_BITS-1:0] smp;
   logic [CNT_W-1:0]       blk_nz;
   logic [CNT_W-1:0]       blk_len;
   logic [SCALE_W-1:0]     scale_sel;
   logic [CNT_W-1:0]       count_inc;
   logic                   up_hit, down_hit;
   logic [RANGE_W-1:0]     range_new;

   // sample field widened, then cut to the converter width
   always_comb begin
      smp = SAMPLE_BITS'(32'(req_tdata[SMP_FIELD_W-1:0]) &
                         ((32'd1 << SAMPLE_BITS) - 32'd1));
   end

   // block length: zero counts as one, clipped to the largest block
   always_comb begin
      blk_nz  = (spb_ff == '0) ? CNT_W'(1) : spb_ff;
      blk_len = (32'(blk_nz) > 32'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : blk_nz;
   end

   always_comb begin
      case (range_ff)
         3'd1:    scale_sel = scale1_ff;
         3'd2:    scale_sel = scale2_ff;
         3'd3:    scale_sel = scale3_ff;
         3'd4:    scale_sel = scale4_ff;
         3'd5:    scale_sel = scale5_ff;
         default: scale_sel = scale1_ff;
      endcase
   end

   // range stepping: high test wins, saturating at the ends
   always_comb begin
      up_hit    = (avg_ff > SUM_W'(th_high_ff));
      down_hit  = !up_hit && (avg_ff < SUM_W'(th_low_ff));
      range_new = range_ff;
      if (up_hit && range_ff < RANGE_MAX) begin
         range_new = range_ff + 1'b1;
      end else if (down_hit && range_ff > RANGE_MIN) begin
         range_new = range_ff - 1'b1;
      end
   end

   assign count_inc  = count_ff + 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      range_in     = range_ff;
      pol_in       = pol_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      volt_in      = volt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_volt_in  = rsp_volt_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_pol_in   = rsp_pol_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      unit_ctl     = '{start: 1'b0, op: OP_MUL};
      unit_a       = sum_ff;
      unit_b       = DIV_W'(sum_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sum_in   = sum_ff + SUM_W'(smp);
               count_in = count_inc;
               pol_in   = req_tuser[0];
               if (count_inc >= blk_len) begin
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_MUL_GO: begin
            unit_ctl = '{start: 1'b1, op: OP_MUL};
            unit_a   = sum_ff;
            unit_b   = DIV_W'(scale_sel) << (DIV_W - SCALE_W);
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (unit_done) begin
               prod_in  = unit_acc;
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            unit_ctl = '{start: 1'b1, op: OP_DIV};
            unit_a   = SUM_W'(blk_len);
            unit_b   = DIV_W'(sum_ff);
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (unit_done) begin
               avg_in   = unit_quot[SUM_W-1:0];
               state_in = ST_VOLT_GO;
            end
         end
         ST_VOLT_GO: begin
            // floor(p / (256 n)) equals floor(floor(p / 256) / n)
            unit_ctl = '{start: 1'b1, op: OP_DIV};
            unit_a   = SUM_W'(blk_len);
            unit_b   = prod_ff[PROD_W-1:VOLT_FRAC];
            state_in = ST_VOLT_WAIT;
         end
         ST_VOLT_WAIT: begin
            if (unit_done) begin
               volt_in  = unit_quot[VOLT_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_volt_in  = volt_ff;
               rsp_used_in  = range_ff;
               rsp_next_in  = range_new;
               rsp_pol_in   = pol_ff;
               rsp_cmd_in   = up_hit | down_hit;
               range_in     = range_new;
               sum_in       = '0;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         range_ff     <= RANGE_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pol_ff      <= pol_in;
      prod_ff     <= prod_in;
      avg_ff      <= avg_in;
      volt_ff     <= volt_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_used_ff <= rsp_used_in;
      rsp_next_ff <= rsp_next_in;
      rsp_pol_ff  <= rsp_pol_in;
      rsp_cmd_ff  <= rsp_cmd_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         th_low_ff  <= TH_LOW_RST;
         th_high_ff <= TH_HIGH_RST;
         spb_ff     <= SPB_RST;
         scale1_ff  <= SCALE_1_RST;
         scale2_ff  <= SCALE_2_RST;
         scale3_ff  <= SCALE_3_RST;
         scale4_ff  <= SCALE_4_RST;
         scale5_ff  <= SCALE_5_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_THRESHOLD_LOW:   th_low_ff  <= csr_wdata[TH_W-1:0];
            REG_THRESHOLD_HIGH:  th_high_ff <= csr_wdata[TH_W-1:0];
            REG_SAMPLES_PER_BLK: spb_ff     <= csr_wdata[CNT_W-1:0];
            REG_SCALE_ONE:       scale1_ff  <= csr_wdata;
            REG_SCALE_TWO:       scale2_ff  <= csr_wdata;
            REG_SCALE_THREE:     scale3_ff  <= csr_wdata;
            REG_SCALE_FOUR:      scale4_ff  <= csr_wdata;
            REG_SCALE_FIVE:      scale5_ff  <= csr_wdata;
            default:             th_low_ff  <= th_low_ff;
         endcase
      end
   end

   avm_shared_unit #(
      .SUM_W (SUM_W)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opnd_a (unit_a),
      .opnd_b (unit_b),
      .done   (unit_done),
      .acc    (unit_acc),
      .quot   (unit_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_next_ff, rsp_used_ff, rsp_volt_ff});
   assign rsp_tuser  = {rsp_cmd_ff, rsp_pol_ff};

endmodule
